>>> sv/sitoa_pkg.sv
// Shared constants, types and elaboration helpers for the decimal text converter.
`default_nettype none
package sitoa_pkg;

	localparam int NumBitsDefault = 32;
	localparam int CharW          = 7;
	localparam int BcdW           = 4;
	localparam int Radix          = 10;

	localparam logic [CharW-1:0] ChZero  = 7'd48;
	localparam logic [CharW-1:0] ChMinus = 7'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Decimal digits needed for the largest magnitude, 2^(bits-1).
	function automatic int num_digits(input int bits);
		longint unsigned p;
		int n;
		p = longint'(1) << (bits - 1);
		n = 0;
		do begin
			n = n + 1;
			p = p / Radix;
		end while (p != 0);
		return n;
	endfunction

endpackage
`default_nettype wire

>>> sv/sitoa_in_if.sv
// Input channel: one signed integer per word.
`default_nettype none
interface sitoa_in_if #(
	parameter int NUM_BITS = sitoa_pkg::NumBitsDefault
);
	logic                valid;
	logic                ready;
	logic [NUM_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

>>> sv/sitoa_out_if.sv
// Output channel: one ASCII character per word, with an end-of-number flag.
`default_nettype none
interface sitoa_out_if;
	logic                        valid;
	logic                        ready;
	logic [sitoa_pkg::CharW-1:0] char_code;
	logic                        last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

>>> sv/signed_int_to_decimal_ascii.sv
// Steps: shift-and-add-3 conversion of all NUM_BITS input bits on one shared BCD adjust unit,
// then a '-' when negative, then one BCD digit per step (leading zeros are dropped but still
// take their step); sign and digit steps wait for a free output slot. One number at a time:
// input ready only between numbers.
// Output characters leave at most one per cycle while the sink is ready.
// Reset (arst_n, asynchronous) returns the sequencer to idle and drops any held output.
`default_nettype none
module signed_int_to_decimal_ascii #(
	parameter int NUM_BITS = sitoa_pkg::NumBitsDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	sitoa_in_if.sink          num,
	sitoa_out_if.source       text
);

	localparam int NumDigits = sitoa_pkg::num_digits(NUM_BITS);
	localparam int DigW      = NumDigits * sitoa_pkg::BcdW;
	localparam int CntW      = $clog2(NUM_BITS);
	localparam logic [CntW-1:0] ConvLast = CntW'(NUM_BITS - 1);
	localparam logic [CntW-1:0] DigLast  = CntW'(NumDigits - 1);

	sitoa_pkg::state_t state_q, state_d;

	logic [NUM_BITS-1:0]        bin_q;
	logic [DigW-1:0]            bcd_q;
	logic [CntW-1:0]            cnt_q;
	logic                       neg_q;
	logic                       started_q;
	logic                       ov_q;
	logic [sitoa_pkg::CharW-1:0] char_q;
	logic                       last_q;

	logic [NUM_BITS-1:0]        mag;
	logic [DigW-1:0]            bcd_adj;
	logic [DigW-1:0]            bcd_shift;
	logic [sitoa_pkg::BcdW-1:0] top_dig;
	logic                       slot_free;
	logic                       conv_done;
	logic                       dig_last;
	logic                       emit_dig;

	assign mag = num.value[NUM_BITS-1] ? (~num.value + 1'b1) : num.value;

	// Add 3 to every digit of five or more, then shift in the next binary bit.
	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_q[i*sitoa_pkg::BcdW +: sitoa_pkg::BcdW] >= 4'd5) begin
				bcd_adj[i*sitoa_pkg::BcdW +: sitoa_pkg::BcdW] =
					bcd_q[i*sitoa_pkg::BcdW +: sitoa_pkg::BcdW] + 4'd3;
			end else begin
				bcd_adj[i*sitoa_pkg::BcdW +: sitoa_pkg::BcdW] =
					bcd_q[i*sitoa_pkg::BcdW +: sitoa_pkg::BcdW];
			end
		end
	end

	assign bcd_shift = {bcd_adj[DigW-2:0], bin_q[NUM_BITS-1]};
	assign top_dig   = bcd_q[DigW-1 -: sitoa_pkg::BcdW];
	assign slot_free = !ov_q || text.ready;
	assign conv_done = (cnt_q == ConvLast);
	assign dig_last  = (cnt_q == DigLast);
	// Drop leading zeros, but always print the units digit.
	assign emit_dig  = (top_dig != '0) || started_q || dig_last;

	always_comb begin
		state_d   = state_q;
		num.ready = 1'b0;
		case (state_q)
			sitoa_pkg::ST_IDLE: begin
				num.ready = 1'b1;
				if (num.valid) state_d = sitoa_pkg::ST_CONV;
			end
			sitoa_pkg::ST_CONV: begin
				if (conv_done) state_d = neg_q ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_EMIT;
			end
			sitoa_pkg::ST_SIGN: begin
				if (slot_free) state_d = sitoa_pkg::ST_EMIT;
			end
			sitoa_pkg::ST_EMIT: begin
				if (slot_free && dig_last) state_d = sitoa_pkg::ST_IDLE;
			end
			default: state_d = sitoa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitoa_pkg::ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (text.ready) ov_q <= 1'b0;
			if (state_q == sitoa_pkg::ST_SIGN && slot_free) ov_q <= 1'b1;
			if (state_q == sitoa_pkg::ST_EMIT && slot_free && emit_dig) ov_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sitoa_pkg::ST_IDLE: begin
				bin_q     <= mag;
				bcd_q     <= '0;
				cnt_q     <= '0;
				neg_q     <= num.value[NUM_BITS-1];
				started_q <= 1'b0;
			end
			sitoa_pkg::ST_CONV: begin
				bcd_q <= bcd_shift;
				bin_q <= {bin_q[NUM_BITS-2:0], 1'b0};
				cnt_q <= conv_done ? '0 : cnt_q + 1'b1;
			end
			sitoa_pkg::ST_SIGN: begin
				if (slot_free) begin
					char_q <= sitoa_pkg::ChMinus;
					last_q <= 1'b0;
				end
			end
			sitoa_pkg::ST_EMIT: begin
				if (slot_free) begin
					bcd_q <= {bcd_q[DigW-sitoa_pkg::BcdW-1:0], {sitoa_pkg::BcdW{1'b0}}};
					cnt_q <= cnt_q + 1'b1;
					if (emit_dig) begin
						char_q    <= sitoa_pkg::ChZero + {3'b000, top_dig};
						last_q    <= dig_last;
						started_q <= 1'b1;
					end
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign text.valid     = ov_q;
	assign text.char_code = char_q;
	assign text.last_char = last_q;

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
`default_nettype none
module testbench;

	localparam int NumBits    = 32;
	localparam int CycleLimit = 200000;
	localparam int TailCycles = 60;
	localparam int CalmFrom   = 1500;
	localparam int CalmTo     = 3500;
	localparam int HoldAt     = 400;
	localparam int HoldLength = 250;

	typedef struct packed {
		logic [sitoa_pkg::CharW-1:0] code;
		logic                        last;
	} text_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sitoa_in_if #(.NUM_BITS(NumBits)) num_ch ();
	sitoa_out_if text_ch ();

	signed_int_to_decimal_ascii #(.NUM_BITS(NumBits)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch.sink),
		.text   (text_ch.source)
	);

	logic [NumBits-1:0] pending_numbers[$];
	text_char_t         expected_chars[$];
	bit                 offering = 1'b0;
	int                 errors = 0;
	int                 cycle_count = 0;
	int                 ready_cycles = 0;
	int                 hold_left = 0;

	always #4 clk = ~clk;

	function automatic bit calm_now();
		return cycle_count >= CalmFrom && cycle_count < CalmTo;
	endfunction

	// Expected text of one number: optional minus, then digits most significant first.
	function automatic void queue_decimal_text(input logic [NumBits-1:0] number);
		logic [NumBits-1:0] magnitude;
		logic [3:0]         digits[$];
		bit                 negative;
		int                 total;
		text_char_t         ch;
		negative  = number[NumBits-1];
		magnitude = negative ? (~number + 1'b1) : number;
		do begin
			digits.push_front(4'(magnitude % sitoa_pkg::Radix));
			magnitude = magnitude / sitoa_pkg::Radix;
		end while (magnitude != 0);
		total = digits.size() + (negative ? 1 : 0);
		if (negative) begin
			ch.code = sitoa_pkg::ChMinus;
			ch.last = (total == 1);
			expected_chars.push_back(ch);
		end
		foreach (digits[i]) begin
			ch.code = sitoa_pkg::ChZero + {3'b000, digits[i]};
			ch.last = (i == digits.size() - 1);
			expected_chars.push_back(ch);
		end
	endfunction

	function automatic void push_number(input longint number);
		pending_numbers.push_back(number[NumBits-1:0]);
	endfunction

	function automatic longint random_number();
		longint lo;
		longint hi;
		longint mag;
		int     digits;
		case ($urandom_range(3, 0))
			0: return longint'($signed($urandom()));
			1: return longint'($urandom_range(2000, 0)) - 1000;
			2: begin
				digits = $urandom_range(10, 1);
				lo = 1;
				repeat (digits - 1) lo = lo * 10;
				hi = lo * 10 - 1;
				if (digits == 1) lo = 0;
				if (hi > 64'sd2147483647) hi = 64'sd2147483647;
				mag = lo + longint'($urandom_range(32'(hi - lo), 0));
				return $urandom_range(1, 0) ? -mag : mag;
			end
			default: begin
				mag = longint'($urandom_range(20, 0));
				return $urandom_range(1, 0) ? (64'sd2147483647 - mag) : (-64'sd2147483648 + mag);
			end
		endcase
	endfunction

	// Sender: hold each word until taken, then offer the next or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (num_ch.valid && num_ch.ready) begin
				queue_decimal_text(num_ch.value);
				offering = 1'b0;
			end
			if (!offering) begin
				if (pending_numbers.size() != 0 &&
				    (calm_now() || $urandom_range(99, 0) >= 18)) begin
					num_ch.value <= pending_numbers.pop_front();
					num_ch.valid <= 1'b1;
					offering = 1'b1;
				end else begin
					num_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure, with one long hold-off early in the run.
	always @(posedge clk) begin
		if (arst_n) begin
			ready_cycles = ready_cycles + 1;
			if (ready_cycles == HoldAt)
				hold_left = HoldLength;
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				text_ch.ready <= 1'b0;
			end else begin
				text_ch.ready <= calm_now() || $urandom_range(99, 0) >= 18;
			end
		end
	end

	// Check each character word against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready) begin
			if (expected_chars.size() == 0) begin
				errors = errors + 1;
				$display("%0t: unexpected char: expected none, actual code %0d last %0b",
					$time, text_ch.char_code, text_ch.last_char);
			end else begin
				text_char_t want;
				want = expected_chars.pop_front();
				if (text_ch.char_code !== want.code) begin
					errors = errors + 1;
					$display("%0t: char_code mismatch: expected %0d, actual %0d",
						$time, want.code, text_ch.char_code);
				end
				if (text_ch.last_char !== want.last) begin
					errors = errors + 1;
					$display("%0t: last_char mismatch: expected %0b, actual %0b",
						$time, want.last, text_ch.last_char);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		num_ch.valid  = 1'b0;
		num_ch.value  = '0;
		text_ch.ready = 1'b0;

		// Zero, single digits, decade edges, both extremes, near-extremes and alternating-bit words.
		push_number(0);
		push_number(1);
		push_number(-1);
		push_number(9);
		push_number(-9);
		push_number(10);
		push_number(-10);
		push_number(99);
		push_number(-100);
		push_number(1000000000);
		push_number(-1000000000);
		push_number(999999999);
		push_number(-999999999);
		push_number(123456789);
		push_number(-123456789);
		push_number(64'sd2147483647);
		push_number(-64'sd2147483648);
		push_number(-64'sd2147483647);
		push_number(64'sd2147483646);
		push_number(1431655765);
		push_number(-1431655766);
		push_number(0);
		repeat (128) push_number(random_number());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() != 0 || offering || expected_chars.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
